// ===== hdl/plt_pkg.sv =====
// plt_pkg: shared types and constants of the positional list table
// request and result structs, operation and status codes, cell command
// no dependencies
`default_nettype none

package plt_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_DELETE_POS = 2'd1,
        OP_DELETE_VAL = 2'd2,
        OP_LOCATE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [CNT_W-1:0]   position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   count;
        logic               empty_res;
    } t_res;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd_kind;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cmd_kind          kind;
        logic [CNT_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
        logic [DATA_W-1:0]  value;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== hdl/plt_cell.sv =====
// plt_cell: one list slot of the chain, holds one word and its match flag
// depends on plt_pkg
`default_nettype none

module plt_cell (
    input  wire logic                          i_clk,
    input  wire logic [plt_pkg::IDX_W-1:0]     i_idx,
    input  wire plt_pkg::t_cell_cmd            i_cmd,
    input  wire logic [plt_pkg::DATA_W-1:0]    i_left,
    input  wire logic [plt_pkg::DATA_W-1:0]    i_right,
    output logic [plt_pkg::DATA_W-1:0]         o_entry,
    output logic                               o_match
);

    logic [plt_pkg::DATA_W-1:0] r_entry;
    logic [plt_pkg::DATA_W-1:0] n_entry;
    logic                       r_match;
    logic                       n_match;
    logic [plt_pkg::CNT_W-1:0]  w_idx;

    assign w_idx = {1'b0, i_idx};

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.kind)
            plt_pkg::CMD_INSERT: begin
                if (w_idx == i_cmd.pos) begin
                    n_entry = i_cmd.value;
                end else if (w_idx > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            plt_pkg::CMD_REMOVE: begin
                if (w_idx >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
        // only slots below the fill count take part in a search
        n_match = (w_idx < i_cmd.count) && (r_entry == i_cmd.value);
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ===== hdl/positional_list_table.sv =====
// positional_list_table: top level of the fixed-capacity ordered list
// depends on plt_pkg and plt_cell
`default_nettype none

// A fixed-capacity ordered list of 64 signed words kept in a chain of cells,
// one word per cell. Each request (insert at position, delete at position,
// delete first equal value, locate first equal value) produces exactly one
// result transfer carrying status, index, count after the request and an
// empty flag. From its transfer in to its result being registered, a request
// is latched, then every cell compares its word against the value, then the
// lowest matching cell is picked with a priority encoder, and finally the
// chain shifts (each cell loads from its neighbour) and the result register
// is written. A new request is taken only once the previous one has written
// its result; a result waiting in the output register stalls only the final
// step of the next request. No clearing pass is needed after reset: only the
// fill count is reset, and words above it are never read.

module positional_list_table (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire plt_pkg::t_req   i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output plt_pkg::t_res        o_out_data
);

    localparam int IW  = plt_pkg::IDX_W;
    localparam int CW  = plt_pkg::CNT_W;
    localparam int DW  = plt_pkg::DATA_W;
    localparam int CAP = plt_pkg::CAPACITY;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_FIND,
        S_APPLY
    } t_state;

    t_state             r_state;
    plt_pkg::t_req      r_req;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_found;
    logic [IW-1:0]      r_fidx;
    logic               r_out_valid;
    plt_pkg::t_res      r_out;
    plt_pkg::t_res      n_out;

    plt_pkg::t_cell_cmd w_cmd;
    plt_pkg::t_cmd_kind w_kind;
    logic [CW-1:0]      w_tpos;
    logic               w_commit;

    logic [DW-1:0]      w_entry [CAP];
    logic [CAP-1:0]     w_match;
    logic [CAP-1:0]     w_first;
    logic [IW-1:0]      w_fidx;

    // chain of cells: each sees its neighbours (head: 0 left, tail: self)
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAP-1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        plt_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IW'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // lowest set match flag, then its binary position
    assign w_first = w_match & (~w_match + CAP'(1));

    always_comb begin
        w_fidx = '0;
        for (int i = 0; i < CAP; i++) begin
            if (w_first[i]) begin
                w_fidx = w_fidx | IW'(i);
            end
        end
    end

    // result may leave when the output register is free or being emptied
    assign w_commit = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    // decide the outcome of the request in the final step
    always_comb begin
        w_kind  = plt_pkg::CMD_HOLD;
        w_tpos  = r_req.position;
        n_count = r_count;
        n_out.status = plt_pkg::ST_OK;
        n_out.index  = '0;
        case (r_req.op)
            plt_pkg::OP_INSERT: begin
                if (r_req.position > r_count) begin
                    n_out.status = plt_pkg::ST_BADPOS;
                end else if (r_count >= CW'(CAP)) begin
                    n_out.status = plt_pkg::ST_FULL;
                end else begin
                    w_kind      = plt_pkg::CMD_INSERT;
                    n_count     = r_count + CW'(1);
                    n_out.index = r_req.position[IW-1:0];
                end
            end
            plt_pkg::OP_DELETE_POS: begin
                if (r_req.position >= r_count) begin
                    n_out.status = plt_pkg::ST_BADPOS;
                end else begin
                    w_kind      = plt_pkg::CMD_REMOVE;
                    n_count     = r_count - CW'(1);
                    n_out.index = r_req.position[IW-1:0];
                end
            end
            plt_pkg::OP_DELETE_VAL: begin
                w_tpos = {1'b0, r_fidx};
                if (!r_found) begin
                    n_out.status = plt_pkg::ST_NOTFOUND;
                end else begin
                    w_kind      = plt_pkg::CMD_REMOVE;
                    n_count     = r_count - CW'(1);
                    n_out.index = r_fidx;
                end
            end
            default: begin
                w_tpos = {1'b0, r_fidx};
                if (!r_found) begin
                    n_out.status = plt_pkg::ST_NOTFOUND;
                end else begin
                    n_out.index = r_fidx;
                end
            end
        endcase
        n_out.count     = n_count;
        n_out.empty_res = (n_count == '0);

        w_cmd.kind  = w_commit ? w_kind : plt_pkg::CMD_HOLD;
        w_cmd.pos   = w_tpos;
        w_cmd.count = r_count;
        w_cmd.value = r_req.value;
    end

    // sequencer, fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (r_state == S_FIND) begin
            r_found <= |w_match;
            r_fidx  <= w_fidx;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAP))
        else $error("fill count above capacity");

    // an error result always reports index zero
    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != plt_pkg::ST_OK) |-> (o_out_data.index == '0))
        else $error("error result with non-zero index");

    // a reported count matches the fill count held after the request
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_data.count == r_count))
        else $error("result count differs from fill count");

    // the fill count only moves when a result is committed
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(r_count))
        else $error("fill count changed outside commit");

endmodule

`default_nettype wire
